FILE: sv/rss_pkg.sv
package rss_pkg;

  // Sample counter width, 4 to 16
  localparam int COUNT_BITS = 16;

  localparam int SAMPLE_W = 24;
  localparam int TOTAL_W  = 40;
  localparam int SQ_W     = 64;
  localparam int ACC_W    = 80;
  localparam int DVS_W    = 32;
  localparam int REM_W    = 41;
  localparam int ROOT_W   = 40;
  localparam int SUB_W    = 43;
  localparam int CNT_W    = 7;

  localparam int MEAN_STEPS = 40;
  localparam int DEV_STEPS  = 80;
  localparam int ROOT_STEPS = 40;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_AVG_DIV,
    ST_AVG_DONE,
    ST_MUL_NLO,
    ST_MUL_NHI,
    ST_MUL_AA,
    ST_MUL_AB,
    ST_MUL_BB,
    ST_MUL_D,
    ST_DEV_DIV,
    ST_SQRT,
    ST_DEV_DONE,
    ST_OUT
  } state_t;

  // Operands for the shared multiplier and subtractor
  typedef struct packed {
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [SUB_W-1:0] sub_a;
    logic [SUB_W-1:0] sub_b;
  } alu_req_t;

  typedef struct packed {
    logic [63:0]      prod;
    logic [SUB_W-1:0] diff;
    logic             ge;
  } alu_rsp_t;

endpackage

FILE: sv/rss_in_if.sv
interface rss_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

FILE: sv/rss_out_if.sv
interface rss_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] minimum;
  logic [23:0] maximum;
  logic [23:0] average;
  logic [23:0] deviation;
  logic        deviation_valid;
  logic [15:0] samples_seen;
  logic        saturated;

  modport source (output valid, output minimum, output maximum, output average,
                  output deviation, output deviation_valid, output samples_seen,
                  output saturated, input ready);
  modport sink (input valid, input minimum, input maximum, input average,
                input deviation, input deviation_valid, input samples_seen,
                input saturated, output ready);
endinterface

FILE: sv/rss_alu.sv
// Shared arithmetic: one 32x32 multiplier and one compare-subtract
module rss_alu (
  input  rss_pkg::alu_req_t req,
  output rss_pkg::alu_rsp_t rsp
);

  logic [rss_pkg::SUB_W:0] diff_full;

  assign diff_full = {1'b0, req.sub_a} - {1'b0, req.sub_b};

  always_comb begin
    rsp.prod = 64'(req.mul_a) * 64'(req.mul_b);
    rsp.diff = diff_full[rss_pkg::SUB_W-1:0];
    rsp.ge   = ~diff_full[rss_pkg::SUB_W];
  end

endmodule

FILE: sv/running_sample_statistics_unit.sv
// Running min / max / mean / sample standard deviation over signed Q12.12
// words. One word is taken at a time; the unit drops ready until the result
// word has been taken. Each word passes an accept state, the compute steps
// and a result state. The compute steps are one square step, 40 restoring
// divide steps for the mean, one step that signs the mean, six multiply
// steps on the one shared 32x32 multiplier, 80 divide steps for the
// variance, 40 square-root steps and one clamp step. The divide and root
// steps all run on the one shared compare-subtract unit. With fewer than
// two samples the variance path is skipped. Once the count reaches its
// limit further samples are ignored and saturated is set.
module running_sample_statistics_unit (
  input logic  clk,
  input logic  rst_n,
  rss_in_if.sink    in_word,
  rss_out_if.source out_word
);

  rss_pkg::state_t state_r, state_nxt;

  logic signed [rss_pkg::SAMPLE_W-1:0] low_r, low_nxt, high_r, high_nxt;
  logic [rss_pkg::COUNT_BITS-1:0]      tally_r, tally_nxt;
  logic signed [rss_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic [rss_pkg::SQ_W-1:0]            sq_r, sq_nxt;
  logic                                ovf_r, ovf_nxt;

  logic [rss_pkg::SAMPLE_W-1:0] mag_r, mag_nxt;
  logic [rss_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic [rss_pkg::DVS_W-1:0]    dvs_r, dvs_nxt;
  logic [rss_pkg::REM_W-1:0]    rem_r, rem_nxt;
  logic [rss_pkg::ROOT_W-1:0]   root_r, root_nxt;
  logic [rss_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [rss_pkg::SAMPLE_W-1:0] avg_r, avg_nxt, dev_r, dev_nxt;

  logic [rss_pkg::TOTAL_W-1:0] abs_total;
  logic signed [rss_pkg::SAMPLE_W-1:0] smp;
  logic [rss_pkg::SUB_W-1:0]   div_part, sqrt_part;
  logic [rss_pkg::ROOT_W:0]    root_inc;
  logic [rss_pkg::ROOT_W-1:0]  dev_round;
  logic [rss_pkg::SAMPLE_W-1:0] q_lo;

  rss_pkg::alu_req_t alu_req;
  rss_pkg::alu_rsp_t alu_rsp;

  rss_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  assign smp       = in_word.sample;
  assign abs_total = total_r[rss_pkg::TOTAL_W-1] ? rss_pkg::TOTAL_W'(-total_r)
                                                  : rss_pkg::TOTAL_W'(total_r);
  assign div_part  = rss_pkg::SUB_W'({rem_r[rss_pkg::DVS_W-1:0],
                                      acc_r[rss_pkg::ACC_W-1]});
  assign sqrt_part = {rem_r, acc_r[rss_pkg::ACC_W-1 -: 2]};
  assign root_inc  = {1'b0, root_r} + (rss_pkg::ROOT_W+1)'(1);
  assign dev_round = root_inc[rss_pkg::ROOT_W:1];
  assign q_lo      = acc_r[rss_pkg::SAMPLE_W-1:0];

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rss_pkg::ST_IDLE;
      low_r   <= '0;
      high_r  <= '0;
      tally_r <= '0;
      total_r <= '0;
      sq_r    <= '0;
      ovf_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      tally_r <= tally_nxt;
      total_r <= total_nxt;
      sq_r    <= sq_nxt;
      ovf_r   <= ovf_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    acc_r  <= acc_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    avg_r  <= avg_nxt;
    dev_r  <= dev_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    tally_nxt = tally_r;
    total_nxt = total_r;
    sq_nxt    = sq_r;
    ovf_nxt   = ovf_r;
    mag_nxt   = mag_r;
    acc_nxt   = acc_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    avg_nxt   = avg_r;
    dev_nxt   = dev_r;
    alu_req   = '0;
    in_word.ready  = 1'b0;
    out_word.valid = 1'b0;

    case (state_r)
      rss_pkg::ST_IDLE: begin
        in_word.ready = 1'b1;
        if (in_word.valid) begin
          state_nxt = rss_pkg::ST_SQUARE;
          if (tally_r == '1) begin
            ovf_nxt = 1'b1;
            mag_nxt = '0;
          end else begin
            if (tally_r == '0 || smp < low_r) low_nxt = smp;
            if (tally_r == '0 || smp > high_r) high_nxt = smp;
            tally_nxt = tally_r + 1'b1;
            total_nxt = total_r + rss_pkg::TOTAL_W'(smp);
            mag_nxt   = smp[rss_pkg::SAMPLE_W-1] ? rss_pkg::SAMPLE_W'(-smp)
                                                 : rss_pkg::SAMPLE_W'(smp);
          end
        end
      end

      // square into the sum, load the mean dividend
      rss_pkg::ST_SQUARE: begin
        alu_req.mul_a = 32'(mag_r);
        alu_req.mul_b = 32'(mag_r);
        sq_nxt  = sq_r + alu_rsp.prod;
        acc_nxt = {abs_total + rss_pkg::TOTAL_W'(tally_r >> 1),
                   rss_pkg::TOTAL_W'(0)};
        dvs_nxt = rss_pkg::DVS_W'(tally_r);
        rem_nxt = '0;
        cnt_nxt = rss_pkg::CNT_W'(rss_pkg::MEAN_STEPS);
        state_nxt = rss_pkg::ST_AVG_DIV;
      end

      // restoring divide, one quotient bit per cycle
      rss_pkg::ST_AVG_DIV, rss_pkg::ST_DEV_DIV: begin
        alu_req.sub_a = div_part;
        alu_req.sub_b = rss_pkg::SUB_W'(dvs_r);
        rem_nxt = alu_rsp.ge ? rss_pkg::REM_W'(alu_rsp.diff[rss_pkg::DVS_W-1:0])
                             : rss_pkg::REM_W'(div_part[rss_pkg::DVS_W-1:0]);
        acc_nxt = {acc_r[rss_pkg::ACC_W-2:0], alu_rsp.ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == rss_pkg::CNT_W'(1)) begin
          if (state_r == rss_pkg::ST_AVG_DIV) begin
            state_nxt = rss_pkg::ST_AVG_DONE;
          end else begin
            rem_nxt   = '0;
            root_nxt  = '0;
            cnt_nxt   = rss_pkg::CNT_W'(rss_pkg::ROOT_STEPS);
            state_nxt = rss_pkg::ST_SQRT;
          end
        end
      end

      rss_pkg::ST_AVG_DONE: begin
        avg_nxt = total_r[rss_pkg::TOTAL_W-1] ? -q_lo : q_lo;
        if (tally_r < rss_pkg::COUNT_BITS'(2)) begin
          dev_nxt   = '0;
          state_nxt = rss_pkg::ST_OUT;
        end else begin
          state_nxt = rss_pkg::ST_MUL_NLO;
        end
      end

      // m = n*S2 - S1^2, then times four
      rss_pkg::ST_MUL_NLO: begin
        alu_req.mul_a = 32'(tally_r);
        alu_req.mul_b = sq_r[31:0];
        acc_nxt   = rss_pkg::ACC_W'(alu_rsp.prod);
        state_nxt = rss_pkg::ST_MUL_NHI;
      end

      rss_pkg::ST_MUL_NHI: begin
        alu_req.mul_a = 32'(tally_r);
        alu_req.mul_b = sq_r[63:32];
        acc_nxt   = acc_r + (rss_pkg::ACC_W'(alu_rsp.prod) << 32);
        state_nxt = rss_pkg::ST_MUL_AA;
      end

      rss_pkg::ST_MUL_AA: begin
        alu_req.mul_a = 32'(abs_total[39:20]);
        alu_req.mul_b = 32'(abs_total[39:20]);
        acc_nxt   = acc_r - (rss_pkg::ACC_W'(alu_rsp.prod) << 40);
        state_nxt = rss_pkg::ST_MUL_AB;
      end

      rss_pkg::ST_MUL_AB: begin
        alu_req.mul_a = 32'(abs_total[39:20]);
        alu_req.mul_b = 32'(abs_total[19:0]);
        acc_nxt   = acc_r - (rss_pkg::ACC_W'(alu_rsp.prod) << 21);
        state_nxt = rss_pkg::ST_MUL_BB;
      end

      rss_pkg::ST_MUL_BB: begin
        alu_req.mul_a = 32'(abs_total[19:0]);
        alu_req.mul_b = 32'(abs_total[19:0]);
        acc_nxt   = (acc_r - rss_pkg::ACC_W'(alu_rsp.prod)) << 2;
        state_nxt = rss_pkg::ST_MUL_D;
      end

      // divisor n*(n-1)
      rss_pkg::ST_MUL_D: begin
        alu_req.mul_a = 32'(tally_r);
        alu_req.mul_b = 32'(tally_r - 1'b1);
        dvs_nxt   = alu_rsp.prod[rss_pkg::DVS_W-1:0];
        rem_nxt   = '0;
        cnt_nxt   = rss_pkg::CNT_W'(rss_pkg::DEV_STEPS);
        state_nxt = rss_pkg::ST_DEV_DIV;
      end

      // integer square root, one root bit per cycle
      rss_pkg::ST_SQRT: begin
        alu_req.sub_a = sqrt_part;
        alu_req.sub_b = rss_pkg::SUB_W'({root_r, 2'b01});
        if (alu_rsp.ge) begin
          rem_nxt  = alu_rsp.diff[rss_pkg::REM_W-1:0];
          root_nxt = {root_r[rss_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = sqrt_part[rss_pkg::REM_W-1:0];
          root_nxt = {root_r[rss_pkg::ROOT_W-2:0], 1'b0};
        end
        acc_nxt = acc_r << 2;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == rss_pkg::CNT_W'(1)) state_nxt = rss_pkg::ST_DEV_DONE;
      end

      // deviation = (isqrt(4m/d) + 1) / 2, clamped
      rss_pkg::ST_DEV_DONE: begin
        dev_nxt = (|dev_round[rss_pkg::ROOT_W-1:rss_pkg::SAMPLE_W]) ? '1
                  : dev_round[rss_pkg::SAMPLE_W-1:0];
        state_nxt = rss_pkg::ST_OUT;
      end

      rss_pkg::ST_OUT: begin
        out_word.valid = 1'b1;
        if (out_word.ready) state_nxt = rss_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = rss_pkg::ST_IDLE;
      end
    endcase
  end

  // Result word
  assign out_word.minimum         = low_r;
  assign out_word.maximum         = high_r;
  assign out_word.average         = avg_r;
  assign out_word.deviation       = dev_r;
  assign out_word.deviation_valid = (tally_r >= rss_pkg::COUNT_BITS'(2));
  assign out_word.samples_seen    = 16'(tally_r);
  assign out_word.saturated       = ovf_r;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_word.valid && in_word.ready |=> !in_word.ready)
    else $error("input taken while busy");

  a_tally_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_word.valid && in_word.ready && tally_r != '1 |=> tally_r == $past(tally_r) + 1'b1)
    else $error("tally did not advance");

  a_dev_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && !out_word.deviation_valid |-> out_word.deviation == '0)
    else $error("deviation nonzero with fewer than two samples");

  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_word.ready && out_word.valid))
    else $error("ready and result valid together");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && out_word.samples_seen != 16'd0 |-> low_r <= high_r)
    else $error("minimum above maximum");

endmodule
